// ===== rtl/core/rgbcf_pkg.sv =====
package rgbcf_pkg;

    // Field widths of the stream items and the configuration registers
    localparam int unsigned CHAN_BITS     = 8;
    localparam int unsigned CFG_W_BITS    = 11;
    localparam int unsigned CFG_H_BITS    = 13;
    localparam int unsigned CFG_MODE_BITS = 2;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 13;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE  = 2'd2;

    // Register reset values
    localparam logic [CFG_W_BITS-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_H_BITS-1:0] RST_FRAME_HEIGHT = 13'd480;

    // Smallest frame edge the counters run with
    localparam int unsigned MIN_EDGE = 3;

    // Reciprocal of 9 in 0.16 fixed point, exact for sums below 32768
    localparam logic [12:0] DIV9_MUL = 13'd7282;

    // Kernel selection
    typedef enum logic [CFG_MODE_BITS-1:0] {
        MODE_BOX   = 2'd0,
        MODE_GAUSS = 2'd1,
        MODE_SHARP = 2'd2
    } t_mode;

    // One pixel, red in the lowest byte as on the stream
    typedef struct packed {
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
    } t_pix;

    // Nine samples of one channel, index 4 is the centre
    typedef logic [8:0][CHAN_BITS-1:0] t_chan_win;

    // Apply the selected 3x3 kernel to one channel
    function automatic logic [CHAN_BITS-1:0] filt_chan(
        input t_chan_win                 c,
        input logic [CFG_MODE_BITS-1:0]  mode
    );
        logic        [11:0] box_sum;
        logic        [24:0] box_prod;
        logic        [11:0] gau_sum;
        logic signed [11:0] shp_sum;
        logic [CHAN_BITS-1:0] res;
        box_sum = 12'(c[0]) + 12'(c[1]) + 12'(c[2]) + 12'(c[3]) + 12'(c[4])
                + 12'(c[5]) + 12'(c[6]) + 12'(c[7]) + 12'(c[8]);
        box_prod = 25'(box_sum) * 25'(DIV9_MUL);
        gau_sum = 12'(c[0]) + 12'(c[2]) + 12'(c[6]) + 12'(c[8])
                + ((12'(c[1]) + 12'(c[3]) + 12'(c[5]) + 12'(c[7])) << 1)
                + (12'(c[4]) << 2);
        shp_sum = $signed((12'(c[4]) << 2) + 12'(c[4]))
                - $signed(12'(c[1])) - $signed(12'(c[3]))
                - $signed(12'(c[5])) - $signed(12'(c[7]));
        case (mode)
            MODE_BOX:   res = box_prod[23:16];
            MODE_GAUSS: res = gau_sum[11:4];
            MODE_SHARP: begin
                if (shp_sum < 12'sd0) begin
                    res = '0;
                end else if (shp_sum > 12'sd255) begin
                    res = '1;
                end else begin
                    res = shp_sum[7:0];
                end
            end
            default:    res = c[4];
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/rgbcf_ram.sv =====
module rgbcf_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port, read data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rgb_3x3_convolution_filter_top.sv =====
// Pipeline: a result is registered in stage A, the stage B window and the output register after the input transfer that
//   completes its neighborhood, i.e. frame_width+1 pixels after its own pixel.
// Throughput: 1 pixel per cycle unless stalled, set by one read and one write per cycle on each line memory.
// Reset: counters, window and output valid clear, registers return to 640x480 box blur;
//   the two line memories are not cleared and need no clearing pass.
module rgb_3x3_convolution_filter_top #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgbcf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rgbcf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // Pixel input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // red, green, blue
    input  logic [0:0]                        s_axis_tuser,  // flush
    // Filtered pixel output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // out_red, out_green, out_blue
    output logic                              m_axis_tlast
);

    import rgbcf_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned RW = HW + 1;
    localparam int unsigned PW = $bits(t_pix);

    // Configuration registers
    logic [CFG_W_BITS-1:0]    r_frame_width;
    logic [CFG_H_BITS-1:0]    r_frame_height;
    logic [CFG_MODE_BITS-1:0] r_filter_mode;

    // Position counters
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    // Stage A: line memory read returns
    logic          r_a_valid;
    logic [CW-1:0] r_a_col;
    t_pix          r_a_pix;
    logic          r_a_emit;
    logic          r_a_filt;
    logic          r_a_last;
    logic          r_a_fwd;
    t_pix          r_a_fw_up;
    t_pix          r_a_fw_mid;

    // Stage B: window
    logic          r_b_valid;
    logic          r_b_emit;
    logic          r_b_filt;
    logic          r_b_last;
    t_pix [8:0]    r_win;

    // Output register
    logic          r_o_valid;
    t_pix          r_o_pix;
    logic          r_o_last;

    logic [WW-1:0] used_w;
    logic [HW-1:0] used_h;
    logic          in_frame;
    logic          step;
    t_pix          in_pix;
    logic          emit;
    logic          interior;
    logic          mode_ok;
    logic          last;
    logic          in_col_end;
    logic          out_col_end;
    logic          out_free;
    logic          b_go;
    logic          b_ready;
    logic          a_ready;
    t_pix          up_rdata;
    t_pix          mid_rdata;
    t_pix          eff_up;
    t_pix          eff_mid;
    t_chan_win     win_r;
    t_chan_win     win_g;
    t_chan_win     win_b;
    t_pix          filt_pix;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_filter_mode  <= MODE_BOX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_FILTER_MODE:  r_filter_mode  <= i_cfg_data[CFG_MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Saturate frame size to the supported range
    always_comb begin
        if (32'(r_frame_width) < MIN_EDGE) begin
            used_w = WW'(MIN_EDGE);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            used_w = WW'(MAX_WIDTH);
        end else begin
            used_w = WW'(r_frame_width);
        end
        if (32'(r_frame_height) < MIN_EDGE) begin
            used_h = HW'(MIN_EDGE);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            used_h = HW'(MAX_HEIGHT);
        end else begin
            used_h = HW'(r_frame_height);
        end
    end

    // Handshake chain: each stage frees when the next one takes its item, stage B also when its item emits nothing
    assign out_free      = !r_o_valid || m_axis_tready;
    assign b_go          = !r_b_emit || out_free;
    assign b_ready       = !r_b_valid || b_go;
    assign a_ready       = !r_a_valid || b_ready;
    assign s_axis_tready = a_ready;

    // Decode the incoming transfer: pixels during the frame, flush ticks while draining
    always_comb begin
        in_frame    = 32'(r_in_row) < 32'(used_h);
        step        = s_axis_tvalid && a_ready
                      && (in_frame ? !s_axis_tuser[0] : s_axis_tuser[0]);
        in_pix      = in_frame ? t_pix'(s_axis_tdata) : '0;
        emit        = (32'(r_in_row) >= 2) || (r_in_row == RW'(1) && r_in_col != '0);
        in_col_end  = (32'(r_in_col) + 1) >= 32'(used_w);
        out_col_end = (32'(r_out_col) + 1) >= 32'(used_w);
        mode_ok     = r_filter_mode == MODE_BOX || r_filter_mode == MODE_GAUSS
                      || r_filter_mode == MODE_SHARP;
        interior    = r_out_col != '0 && !out_col_end && r_out_row != '0
                      && (32'(r_out_row) + 1) < 32'(used_h);
        last        = (32'(r_out_row) + 1) >= 32'(used_h) && out_col_end;
    end

    // Advance input and output positions, restart both at frame end
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (step) begin
            if (in_col_end) begin
                n_in_col = '0;
                n_in_row = RW'(r_in_row + 1'b1);
            end else begin
                n_in_col = CW'(r_in_col + 1'b1);
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = RW'(r_out_row + 1'b1);
                end else begin
                    n_out_col = CW'(r_out_col + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Line memories: upper row and middle row above the input pixel
    rgbcf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (eff_mid),
        .i_re    (step),
        .i_raddr (r_in_col),
        .o_rdata (up_rdata)
    );

    rgbcf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_ram_middle (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (r_a_pix),
        .i_re    (step),
        .i_raddr (r_in_col),
        .o_rdata (mid_rdata)
    );

    // Forward the pending write when the next read hits the same column
    assign eff_up  = r_a_fwd ? r_a_fw_up  : up_rdata;
    assign eff_mid = r_a_fwd ? r_a_fw_mid : mid_rdata;

    // Stage A: hold the transfer while its memory reads return
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_a_col    <= r_in_col;
            r_a_pix    <= in_pix;
            r_a_emit   <= emit;
            r_a_filt   <= interior && mode_ok;
            r_a_last   <= last;
            r_a_fwd    <= r_a_valid && (r_a_col == r_in_col);
            r_a_fw_up  <= eff_mid;
            r_a_fw_mid <= r_a_pix;
        end
    end

    // Stage B: shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_emit  <= 1'b0;
            r_win     <= '0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_b_emit <= r_a_emit;
                r_b_filt <= r_a_filt;
                r_b_last <= r_a_last;
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= eff_up;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= eff_mid;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_a_pix;
            end
        end
    end

    // Split the window into channels and filter each
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            win_r[i] = r_win[i].red;
            win_g[i] = r_win[i].green;
            win_b[i] = r_win[i].blue;
        end
        filt_pix.red   = filt_chan(win_r, r_filter_mode);
        filt_pix.green = filt_chan(win_g, r_filter_mode);
        filt_pix.blue  = filt_chan(win_b, r_filter_mode);
    end

    // Output register: load a result, drop valid once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_b_valid && r_b_emit && out_free) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_emit && out_free) begin
            r_o_pix  <= r_b_filt ? filt_pix : r_win[4];
            r_o_last <= r_b_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_pix;
    assign m_axis_tlast  = r_o_last;

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbcf_pkg::*;

    localparam int unsigned FRAME_MAX_W  = 1024;
    localparam int unsigned FRAME_MAX_H  = 4096;
    localparam int          RANDOM_ITEMS = 520;
    localparam int          WIDE_PIXELS  = 520;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          REPORT_MAX   = 10;
    // Index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 flush;
    } pixel_item_t;

    typedef struct {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 frame_end;
    } filtered_pix_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [23:0]              s_axis_tdata = '0;   // red, green, blue
    logic [0:0]               s_axis_tuser = '0;   // flush
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [23:0]              m_axis_tdata;        // out_red, out_green, out_blue
    logic                     m_axis_tlast;

    pixel_item_t   pixel_q[$];
    filtered_pix_t filtered_q[$];
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            mismatch_cnt = 0;
    int            cycle_cnt = 0;

    // Shadow of the filter state
    logic [23:0]              upper_row  [FRAME_MAX_W];
    logic [23:0]              middle_row [FRAME_MAX_W];
    logic [23:0]              win [9];
    int unsigned              in_col, in_row, out_col, out_row;
    logic [CFG_W_BITS-1:0]    cfg_width;
    logic [CFG_H_BITS-1:0]    cfg_height;
    logic [CFG_MODE_BITS-1:0] cfg_mode;

    rgb_3x3_convolution_filter_top #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply the selected kernel to one channel of the window
    function automatic logic [CHAN_BITS-1:0] kernel_channel(input int ch);
        int s [9];
        int acc;
        for (int i = 0; i < 9; i++) s[i] = int'(win[i][8*ch +: 8]);
        case (cfg_mode)
            MODE_BOX: acc = (s[0] + s[1] + s[2] + s[3] + s[4] + s[5] + s[6] + s[7] + s[8]) / 9;
            MODE_GAUSS: acc = (s[0] + 2*s[1] + s[2] + 2*s[3] + 4*s[4] + 2*s[5]
                               + s[6] + 2*s[7] + s[8]) / 16;
            MODE_SHARP: begin
                acc = 5*s[4] - s[1] - s[3] - s[5] - s[7];
                if (acc < 0) acc = 0;
                else if (acc > 255) acc = 255;
            end
            default: acc = s[4];
        endcase
        return 8'(acc);
    endfunction

    // Advance the shadow filter by one accepted transfer, queue the pixel it releases
    task automatic convolve_pixel(input logic [23:0] pix_in, input logic flush_in);
        int unsigned   fw, fh, col;
        logic [23:0]   pix, up, mid;
        logic          emit, interior;
        filtered_pix_t res;
        fw = cfg_width;
        fh = cfg_height;
        if (fw < MIN_EDGE) fw = MIN_EDGE;
        if (fw > FRAME_MAX_W) fw = FRAME_MAX_W;
        if (fh < MIN_EDGE) fh = MIN_EDGE;
        if (fh > FRAME_MAX_H) fh = FRAME_MAX_H;
        pix = pix_in;
        // Flush inside the frame and pixels while draining are dropped
        if (in_row < fh) begin
            if (flush_in) return;
        end else begin
            if (!flush_in) return;
            pix = '0;
        end
        col = in_col;
        if (col >= FRAME_MAX_W) col = 0;
        up  = upper_row[col];
        mid = middle_row[col];
        upper_row[col]  = mid;
        middle_row[col] = pix;
        win[0] = win[1]; win[1] = win[2]; win[2] = up;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = pix;
        emit = (in_row >= 2) || (in_row == 1 && col >= 1);
        if (col + 1 >= fw) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col = col + 1;
        end
        if (!emit) return;
        interior = out_col >= 1 && out_col + 1 < fw && out_row >= 1 && out_row + 1 < fh;
        if (interior) begin
            res.red   = kernel_channel(0);
            res.green = kernel_channel(1);
            res.blue  = kernel_channel(2);
        end else begin
            res.red   = win[4][7:0];
            res.green = win[4][15:8];
            res.blue  = win[4][23:16];
        end
        res.frame_end = (out_row + 1 >= fh) && (out_col + 1 >= fw);
        filtered_q.push_back(res);
        if (res.frame_end) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (out_col + 1 >= fw) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    // Pixel driver: present the next queued item once the previous one is taken
    always @(posedge i_clk) begin
        pixel_item_t it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {it.blue, it.green, it.red};
                s_axis_tuser  <= it.flush;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: check output transfers, then update the shadow state from input side
    always @(posedge i_clk) begin
        filtered_pix_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_MAX_W; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 9; i++) win[i] = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            cfg_width  = RST_FRAME_WIDTH;
            cfg_height = RST_FRAME_HEIGHT;
            cfg_mode   = MODE_BOX;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected pixel r %0d g %0d b %0d end %0d",
                                 m_axis_tdata[7:0], m_axis_tdata[15:8],
                                 m_axis_tdata[23:16], m_axis_tlast);
                end else begin
                    want = filtered_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.red || m_axis_tdata[15:8] !== want.green ||
                        m_axis_tdata[23:16] !== want.blue || m_axis_tlast !== want.frame_end) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display({"pixel mismatch: expected r %0d g %0d b %0d end %0d,",
                                      " got r %0d g %0d b %0d end %0d"},
                                     want.red, want.green, want.blue, want.frame_end,
                                     m_axis_tdata[7:0], m_axis_tdata[15:8],
                                     m_axis_tdata[23:16], m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                convolve_pixel(s_axis_tdata, s_axis_tuser[0]);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  cfg_width  = i_cfg_data[CFG_W_BITS-1:0];
                    CFG_FRAME_HEIGHT: cfg_height = i_cfg_data[CFG_H_BITS-1:0];
                    CFG_FILTER_MODE:  cfg_mode   = i_cfg_data[CFG_MODE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [CHAN_BITS-1:0] rand_chan();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_item_t it;
        it.red = r;
        it.green = g;
        it.blue = b;
        it.flush = 1'b0;
        pixel_q.push_back(it);
    endtask

    task automatic push_flush();
        pixel_item_t it;
        it.red = rand_chan();
        it.green = rand_chan();
        it.blue = rand_chan();
        it.flush = 1'b1;
        pixel_q.push_back(it);
    endtask

    task automatic set_idling(input int ph);
        case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    // Hold until every queued transfer is taken and every pixel has come out
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One frame of random pixels plus the drain ticks, optionally with defects
    task automatic push_frame(input int fw, input int fh, input bit irregular, input bit pause_mid);
        bit drop_last;
        drop_last = irregular && ($urandom_range(19) == 0);
        for (int y = 0; y < fh; y++) begin
            for (int x = 0; x < fw; x++) begin
                if (!(drop_last && y == fh - 1 && x == fw - 1))
                    push_pixel(rand_chan(), rand_chan(), rand_chan());
                if (irregular && $urandom_range(49) == 0) push_flush();
            end
            if (pause_mid && y == fh / 2) wait_idle();
        end
        if (irregular && $urandom_range(9) == 0) push_pixel(rand_chan(), rand_chan(), rand_chan());
        repeat (fw + 1) push_flush();
        if (irregular && $urandom_range(4) == 0) repeat (2) push_flush();
    endtask

    initial begin : stimulus
        int fw, fh, frame_no, rand_items;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Checkerboard 4x3 frame in sharpen mode: both clamp limits on every channel,
        // height register below range, a stray flush mid-frame and a pixel while draining
        set_idling(0);
        cfg_write(CFG_FRAME_WIDTH, 13'd4);
        cfg_write(CFG_FRAME_HEIGHT, 13'd1);
        cfg_write(CFG_FILTER_MODE, 13'(MODE_SHARP));
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 4; x++) begin
                if ((x + y) % 2 == 0) push_pixel(8'hFF, 8'h00, 8'hFF);
                else push_pixel(8'h00, 8'hFF, 8'h01);
                if (y == 1 && x == 1) push_flush();
            end
        end
        push_pixel(8'h5A, 8'hA5, 8'h3C);
        repeat (6) push_flush();
        wait_idle();

        // Width register above range, a long first row into the upper half of the
        // line memories, then narrow the frame mid-row and finish it at width 3
        set_idling(3);
        cfg_write(CFG_FRAME_WIDTH, 13'h7FF);
        cfg_write(CFG_FRAME_HEIGHT, 13'd0);
        cfg_write(CFG_FILTER_MODE, 13'(MODE_GAUSS));
        cfg_write(CFG_UNUSED, 13'($urandom));
        repeat (WIDE_PIXELS) push_pixel(rand_chan(), rand_chan(), rand_chan());
        wait_idle();
        cfg_write(CFG_FRAME_WIDTH, 13'd3);
        repeat (7) push_pixel(rand_chan(), rand_chan(), rand_chan());
        repeat (4) push_flush();
        wait_idle();

        // Tallest frame, cut short by resizing mid-frame
        set_idling(1);
        cfg_write(CFG_FRAME_WIDTH, 13'd0);
        cfg_write(CFG_FRAME_HEIGHT, 13'(FRAME_MAX_H));
        cfg_write(CFG_FILTER_MODE, 13'(MODE_SHARP));
        repeat (15) push_pixel(rand_chan(), rand_chan(), rand_chan());
        wait_idle();
        cfg_write(CFG_FRAME_WIDTH, 13'd5);
        cfg_write(CFG_FRAME_HEIGHT, 13'h1FFF);
        cfg_write(CFG_FILTER_MODE, 13'(MODE_BOX));
        repeat (6) push_pixel(rand_chan(), rand_chan(), rand_chan());
        wait_idle();
        cfg_write(CFG_FRAME_HEIGHT, 13'd1);
        repeat (6) push_flush();
        wait_idle();

        // Random frames, small sizes, all modes, idling rotated every few frames
        frame_no = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (frame_no == 0 || $urandom_range(2) != 0) begin
                wait_idle();
                set_idling((frame_no / 3) % 4);
                fw = ($urandom_range(6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
                fh = ($urandom_range(6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
                cfg_write(CFG_FRAME_WIDTH, {2'($urandom_range(3)), 11'(fw)});
                cfg_write(CFG_FRAME_HEIGHT, 13'(fh));
                cfg_write(CFG_FILTER_MODE, {11'($urandom), 2'($urandom_range(3))});
                if (fw < MIN_EDGE) fw = MIN_EDGE;
                if (fh < MIN_EDGE) fh = MIN_EDGE;
            end else begin
                while (pixel_q.size() > 4) @(negedge i_clk);
                set_idling((frame_no / 3) % 4);
            end
            push_frame(fw, fh, 1'b1, $urandom_range(9) == 0);
            rand_items += fw * fh + fw + 1;
            frame_no++;
        end

        wait_idle();
        if (mismatch_cnt == 0 && filtered_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
